[design/u8u7_pkg.sv]
// ---------------------------------------------------------------------------
// u8u7_pkg
// Shared types, constants and helper functions for the URL path to
// modified UTF-7 converter.
// ---------------------------------------------------------------------------
package u8u7_pkg;

  localparam int QueueDepthDef = 4;

  // ascii codes used by the converter
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChDash    = 8'h2D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // classified entry handed from front to back
  typedef struct packed {
    logic       err;
    logic [7:0] ch;
    logic       last;
  } entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PRE_PAD,
    B_PRE_DASH,
    B_CHAR,
    B_AMP_DASH,
    B_OPEN,
    B_LOAD,
    B_DIGIT,
    B_END_PAD,
    B_END_DASH,
    B_FLUSH,
    B_ERR
  } back_state_t;

  // modified base64 alphabet
  function automatic logic [7:0] mb64_digit(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2C;
    end
    return r;
  endfunction

  // hex digit value, bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

[design/url_utf8_to_modified_utf7.sv]
// ---------------------------------------------------------------------------
// url_utf8_to_modified_utf7
// Percent-encoded UTF-8 URL path to modified UTF-7 mailbox name converter.
// ---------------------------------------------------------------------------
// channel  | dir | payload    | handshake
// in       | in  | in_item_t  | in_valid / in_ready
// out      | out | out_item_t | out_valid / out_ready
//
// The front takes input bytes while the queue has room; the back sequencer
// emits the output bytes of each entry in order and may stall on out_ready.
// After a cut-short percent escape the front pushes the held byte before
// it takes the next input byte.
// Reset is synchronous and clears all conversion state; the queue lets the
// front keep taking bytes while the output side is stalled.
module url_utf8_to_modified_utf7 #(
  parameter int QueueDepth = u8u7_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8u7_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output u8u7_pkg::out_item_t out_data
);
  import u8u7_pkg::*;

  logic   push, q_full, pop, q_empty;
  entry_t push_data, head;

  u8u7_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .push, .push_data, .q_full
  );

  u8u7_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push, .push_data, .full(q_full),
    .pop, .empty(q_empty), .head
  );

  u8u7_back u_back (
    .clk, .rst, .q_empty, .head, .pop,
    .out_valid, .out_ready, .out_data
  );

endmodule

[design/u8u7_front.sv]
// ---------------------------------------------------------------------------
// u8u7_front
// Accepts path bytes, resolves percent escapes and discarding, and pushes
// classified entries into the queue.
// ---------------------------------------------------------------------------
module u8u7_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8u7_pkg::in_item_t in_data,
  output logic              push,
  output u8u7_pkg::entry_t  push_data,
  input  logic              q_full
);
  import u8u7_pkg::*;

  logic [1:0] percent_count;
  logic [7:0] percent_first_digit;
  logic       discarding;
  logic       pend;
  logic [7:0] pend_ch;
  logic       take;
  logic [4:0] hi, lo;

  assign in_ready = !q_full && !pend;
  assign take     = in_valid && in_ready;
  assign hi       = hex_val(percent_first_digit);
  assign lo       = hex_val(in_data.in_byte);

  // classify the accepted byte
  always_comb begin
    push      = 1'b0;
    push_data = '{err: 1'b0, ch: in_data.in_byte, last: in_data.in_last};
    if (pend) begin
      push      = !q_full;
      push_data = '{err: 1'b0, ch: pend_ch, last: 1'b1};
    end else if (take && !discarding) begin
      unique case (percent_count)
        2'd0: push = !(in_data.in_byte == ChPercent && !in_data.in_last);
        2'd1: begin
          push      = in_data.in_last;
          push_data = '{err: 1'b0, ch: ChPercent, last: 1'b0};
        end
        default: begin
          push = 1'b1;
          if (hi[4] || lo[4]) begin
            push_data = '{err: 1'b1, ch: 8'h00, last: 1'b1};
          end else begin
            push_data = '{err: 1'b0, ch: {hi[3:0], lo[3:0]}, last: in_data.in_last};
          end
        end
      endcase
    end
  end

  // percent and discard state
  always_ff @(posedge clk) begin
    if (rst) begin
      percent_count       <= 2'd0;
      percent_first_digit <= 8'h00;
      discarding          <= 1'b0;
      pend                <= 1'b0;
    end else if (pend) begin
      if (!q_full) pend <= 1'b0;
    end else if (take) begin
      if (discarding) begin
        if (in_data.in_last) discarding <= 1'b0;
      end else begin
        unique case (percent_count)
          2'd0: if (in_data.in_byte == ChPercent && !in_data.in_last) percent_count <= 2'd1;
          2'd1: begin
            if (in_data.in_last) begin
              percent_count <= 2'd0;
              pend          <= 1'b1;
            end else begin
              percent_first_digit <= in_data.in_byte;
              percent_count       <= 2'd2;
            end
          end
          default: begin
            percent_count       <= 2'd0;
            percent_first_digit <= 8'h00;
            if ((hi[4] || lo[4]) && !in_data.in_last) discarding <= 1'b1;
          end
        endcase
      end
    end
  end

  // held byte after a cut-short escape
  always_ff @(posedge clk) begin
    if (take && !pend) pend_ch <= in_data.in_byte;
  end

endmodule

[design/u8u7_queue.sv]
// ---------------------------------------------------------------------------
// u8u7_queue
// Small entry queue between front and back.
// ---------------------------------------------------------------------------
module u8u7_queue #(
  parameter int Depth = u8u7_pkg::QueueDepthDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8u7_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output u8u7_pkg::entry_t head
);
  import u8u7_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t        mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

[design/u8u7_back.sv]
// ---------------------------------------------------------------------------
// u8u7_back
// Executes queued entries: UTF-8 assembly, UTF-16 split and modified
// base64 packing, one queued entry at a time.
// ---------------------------------------------------------------------------
module u8u7_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  u8u7_pkg::entry_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8u7_pkg::out_item_t out_data
);
  import u8u7_pkg::*;

  back_state_t state, state_next;

  // conversion state
  logic        base64_mode;
  logic [19:0] bit_buffer;
  logic [4:0]  bits_pending;
  logic [20:0] code_point;
  logic [2:0]  seq_length, seq_position;
  // current entry
  logic [7:0]  ch;
  logic        last;
  logic        have_cp, two_units, unit_sel;
  logic [15:0] unit1, unit2;
  // one-byte hold so the final byte of an entry can be marked
  logic        hold_valid;
  logic [7:0]  hold_byte;

  logic        printable, out_free, emit_v, stall, advance;
  logic [7:0]  emit_b;
  logic [4:0]  dig_sh;
  logic [5:0]  pad_idx;
  // decode of the head entry
  logic [20:0] cp_n, cp_x;
  logic [2:0]  len_n, pos_n;
  logic        have_n, ovl;

  assign printable = head.ch >= 8'h20 && head.ch <= 8'h7E;
  assign out_free  = !out_valid || out_ready;
  assign dig_sh    = bits_pending - 5'd6;
  assign pad_idx   = 6'(bit_buffer[5:0] << (3'd6 - bits_pending[2:0]));
  assign pop       = (state == B_IDLE) && !q_empty;
  assign cp_x      = cp_n - 21'h010000;

  // utf-8 assembly of a non-printable byte
  always_comb begin
    cp_n   = code_point;
    len_n  = seq_length;
    pos_n  = seq_position;
    have_n = 1'b0;
    ovl    = 1'b0;
    if (head.ch < 8'h80) begin
      cp_n   = {13'd0, head.ch};
      len_n  = 3'd0;
      have_n = 1'b1;
    end else if (seq_length != 3'd0) begin
      cp_n  = {code_point[14:0], head.ch[5:0]};
      pos_n = seq_position + 3'd1;
      if (pos_n >= seq_length) begin
        ovl = (cp_n < 21'h80 && seq_length > 3'd1) ||
              (cp_n < 21'h800 && seq_length > 3'd2) ||
              (cp_n < 21'h10000 && seq_length > 3'd3);
        len_n  = 3'd0;
        have_n = !ovl;
      end
    end else begin
      pos_n = 3'd1;
      if (head.ch < 8'hE0) begin
        len_n = 3'd2;
        cp_n  = {16'd0, head.ch[4:0]};
      end else if (head.ch < 8'hF0) begin
        len_n = 3'd3;
        cp_n  = {17'd0, head.ch[3:0]};
      end else begin
        len_n = 3'd4;
        cp_n  = {19'd0, head.ch[1:0]};
      end
    end
  end

  // byte produced in the current state
  always_comb begin
    emit_v = 1'b0;
    emit_b = ChDash;
    unique case (state)
      B_PRE_PAD, B_END_PAD: begin
        emit_v = bits_pending != 5'd0;
        emit_b = mb64_digit(pad_idx);
      end
      B_PRE_DASH, B_END_DASH, B_AMP_DASH: emit_v = 1'b1;
      B_CHAR: begin
        emit_v = 1'b1;
        emit_b = ch;
      end
      B_OPEN: begin
        emit_v = 1'b1;
        emit_b = ChAmp;
      end
      B_DIGIT: begin
        emit_v = bits_pending >= 5'd6;
        emit_b = mb64_digit(6'(bit_buffer >> dig_sh));
      end
      default: emit_v = 1'b0;
    endcase
  end

  always_comb begin
    stall = emit_v && hold_valid && !out_free;
    if (state == B_FLUSH) stall = hold_valid && !out_free;
    if (state == B_ERR) stall = !out_free;
    advance = !stall;
  end

  // next state
  always_comb begin
    state_next = state;
    if (advance) begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (head.err) state_next = B_ERR;
            else if (printable) state_next = base64_mode ? B_PRE_PAD : B_CHAR;
            else if (!base64_mode) state_next = B_OPEN;
            else state_next = have_n ? B_LOAD : B_END_PAD;
          end
        end
        B_PRE_PAD:  state_next = B_PRE_DASH;
        B_PRE_DASH: state_next = B_CHAR;
        B_CHAR:     state_next = (ch == ChAmp) ? B_AMP_DASH : B_FLUSH;
        B_AMP_DASH: state_next = B_FLUSH;
        B_OPEN:     state_next = have_cp ? B_LOAD : B_END_PAD;
        B_LOAD:     state_next = B_DIGIT;
        B_DIGIT: begin
          if (bits_pending < 5'd6) state_next = (two_units && !unit_sel) ? B_LOAD : B_END_PAD;
        end
        B_END_PAD:  state_next = (last && base64_mode) ? B_END_DASH : B_FLUSH;
        B_END_DASH: state_next = B_FLUSH;
        default:    state_next = B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // conversion state and output staging
  always_ff @(posedge clk) begin
    if (rst) begin
      base64_mode  <= 1'b0;
      bit_buffer   <= '0;
      bits_pending <= '0;
      code_point   <= '0;
      seq_length   <= '0;
      seq_position <= '0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (advance && emit_v && !(state == B_END_PAD && !(last && base64_mode))) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
          out_data  <= '{out_byte: hold_byte, out_last: 1'b0, out_error: 1'b0};
        end
        hold_valid <= 1'b1;
        hold_byte  <= emit_b;
      end
      if (advance) begin
        unique case (state)
          B_IDLE: begin
            if (!q_empty && !head.err && !printable) begin
              code_point   <= cp_n;
              seq_length   <= len_n;
              seq_position <= pos_n;
            end
          end
          B_PRE_DASH, B_END_DASH: begin
            base64_mode  <= 1'b0;
            bits_pending <= '0;
            bit_buffer   <= '0;
          end
          B_OPEN: base64_mode <= 1'b1;
          B_LOAD: begin
            bit_buffer   <= {bit_buffer[3:0], unit_sel ? unit2 : unit1};
            bits_pending <= bits_pending + 5'd16;
          end
          B_DIGIT: if (bits_pending >= 5'd6) bits_pending <= dig_sh;
          B_FLUSH: begin
            if (hold_valid) begin
              out_valid  <= 1'b1;
              out_data   <= '{out_byte: hold_byte, out_last: last, out_error: 1'b0};
              hold_valid <= 1'b0;
            end
            if (last) begin
              base64_mode  <= 1'b0;
              bit_buffer   <= '0;
              bits_pending <= '0;
              code_point   <= '0;
              seq_length   <= '0;
              seq_position <= '0;
            end
          end
          B_ERR: begin
            out_valid    <= 1'b1;
            out_data     <= '{out_byte: 8'h00, out_last: 1'b1, out_error: 1'b1};
            base64_mode  <= 1'b0;
            bit_buffer   <= '0;
            bits_pending <= '0;
            code_point   <= '0;
            seq_length   <= '0;
            seq_position <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // per-entry registers
  always_ff @(posedge clk) begin
    if (pop) begin
      ch        <= head.ch;
      last      <= head.last;
      have_cp   <= have_n;
      two_units <= cp_n >= 21'h010000;
      unit_sel  <= 1'b0;
      unit1     <= (cp_n >= 21'h010000) ? 16'hD800 + {5'd0, cp_x[20:10]} : cp_n[15:0];
      unit2     <= 16'hDC00 + {6'd0, cp_x[9:0]};
    end else if (state == B_DIGIT && bits_pending < 5'd6) begin
      unit_sel <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_error |-> out_data.out_last)
    else $error("error item without last mark");
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> !hold_valid)
    else $error("held byte left over at entry end");
  a_idle_bits: assert property (@(posedge clk) disable iff (rst)
    state == B_IDLE |-> bits_pending < 5'd6)
    else $error("base64 bits not drained");
`endif

endmodule

[tb/url_utf8_to_modified_utf7_test.sv]
// ---------------------------------------------------------------------------
// url_utf8_to_modified_utf7_test
// Drives percent-encoded UTF-8 path strings into the converter and checks
// every mailbox-name byte against a behavioral model of the conversion.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module url_utf8_to_modified_utf7_test;
  import u8u7_pkg::*;

  // behavioral model of the converter plus store of expected output items
  class mailbox_name_scoreboard;
    out_item_t pending_bytes[$];
    int        fail_count;
    bit        b64_on;
    bit [19:0] shift_reg;
    int        shift_bits;
    bit [20:0] cp_acc;
    int        utf_len;
    int        utf_pos;
    int        pct_state;
    bit [7:0]  pct_hi;
    bit        skip_rest;
    out_item_t step_bytes[$];

    function void clear_state();
      b64_on = 0; shift_reg = 0; shift_bits = 0; cp_acc = 0;
      utf_len = 0; utf_pos = 0; pct_state = 0; pct_hi = 0; skip_rest = 0;
    endfunction

    function bit [7:0] b64_char(bit [5:0] v);
      string alpha;
      alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";
      return alpha[v];
    endfunction

    function void push_byte(bit [7:0] b);
      out_item_t r;
      r.out_byte = b; r.out_last = 0; r.out_error = 0;
      if (step_bytes.size() < 12) step_bytes.push_back(r);
    endfunction

    function void close_b64();
      bit [19:0] sh;
      if (b64_on) begin
        sh = shift_reg << (6 - shift_bits);
        if (shift_bits != 0 && shift_bits < 6) push_byte(b64_char(sh[5:0]));
        push_byte(ChDash);
        b64_on = 0; shift_bits = 0; shift_reg = 0;
      end
    endfunction

    function void put_utf16(bit [31:0] unit);
      bit [19:0] sh;
      shift_reg = (shift_reg << 16) | unit[15:0];
      shift_bits += 16;
      while (shift_bits >= 6) begin
        shift_bits -= 6;
        sh = shift_reg >> shift_bits;
        push_byte(b64_char(sh[5:0]));
      end
      shift_bits &= 7;
    endfunction

    function int hexv(bit [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    function void convert_char(bit [7:0] c);
      bit [31:0] cp;
      if (c >= 8'h20 && c <= 8'h7E) begin
        close_b64();
        push_byte(c);
        if (c == ChAmp) push_byte(ChDash);
        return;
      end
      if (!b64_on) begin
        push_byte(ChAmp);
        b64_on = 1;
      end
      if (c < 8'h80) begin
        cp_acc = c; utf_len = 1;
      end else if (utf_len != 0) begin
        cp_acc = (cp_acc << 6) | c[5:0];
        utf_pos = (utf_pos + 1) & 7;
        if (utf_pos < utf_len) return;
      end else begin
        utf_pos = 1;
        if (c < 8'hE0) begin utf_len = 2; cp_acc = c & 8'h1F; end
        else if (c < 8'hF0) begin utf_len = 3; cp_acc = c & 8'h0F; end
        else begin utf_len = 4; cp_acc = c & 8'h03; end
        return;
      end
      // overlong forms are dropped
      if ((cp_acc < 21'h80 && utf_len > 1) || (cp_acc < 21'h800 && utf_len > 2) ||
          (cp_acc < 21'h10000 && utf_len > 3)) begin
        utf_len = 0;
        return;
      end
      utf_len = 0;
      cp = cp_acc;
      if (cp >= 32'h10000) begin
        cp -= 32'h10000;
        put_utf16((cp >> 10) + 32'hD800);
        cp = (cp & 32'h3FF) + 32'hDC00;
      end
      cp_acc = cp[20:0];
      put_utf16(cp);
    endfunction

    // note an accepted input item and queue the output bytes it causes
    function void note_input(in_item_t it);
      int hi, lo;
      out_item_t r;
      step_bytes.delete();
      if (skip_rest) begin
        if (it.in_last) clear_state();
        return;
      end
      if (pct_state == 0) begin
        if (it.in_byte == ChPercent && !it.in_last) begin
          pct_state = 1;
          return;
        end
        convert_char(it.in_byte);
      end else if (pct_state == 1) begin
        if (!it.in_last) begin
          pct_hi = it.in_byte; pct_state = 2;
          return;
        end
        pct_state = 0;
        convert_char(ChPercent);
        convert_char(it.in_byte);
      end else begin
        hi = hexv(pct_hi);
        lo = hexv(it.in_byte);
        pct_state = 0; pct_hi = 0;
        if (hi < 0 || lo < 0) begin
          r.out_byte = 0; r.out_last = 1; r.out_error = 1;
          pending_bytes.push_back(r);
          clear_state();
          if (!it.in_last) skip_rest = 1;
          return;
        end
        convert_char(8'((hi << 4) | lo));
      end
      if (it.in_last) begin
        close_b64();
        clear_state();
        if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].out_last = 1;
      end
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
    endfunction

    // compare one output item with the oldest expected one
    function void check_output(out_item_t got);
      out_item_t exp_item;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output item %h", got);
        fail_count++;
        return;
      end
      exp_item = pending_bytes.pop_front();
      if (got.out_byte !== exp_item.out_byte) begin
        $error("out_byte expected %h actual %h", exp_item.out_byte, got.out_byte);
        fail_count++;
      end
      if (got.out_last !== exp_item.out_last) begin
        $error("out_last expected %b actual %b", exp_item.out_last, got.out_last);
        fail_count++;
      end
      if (got.out_error !== exp_item.out_error) begin
        $error("out_error expected %b actual %b", exp_item.out_error, got.out_error);
        fail_count++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  mailbox_name_scoreboard sb;
  bit        calm_sender;
  bit        calm_receiver;
  bit        hold_receiver;
  bit        stim_done;
  in_item_t  path_bytes[$];

  url_utf8_to_modified_utf7 uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // random byte leaning toward the interesting classes
  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(8'h20, 8'h7E));
      1: return 8'($urandom_range(8'h00, 8'h1F));
      2: return 8'($urandom_range(8'h80, 8'hBF));
      3: return 8'($urandom_range(8'hC0, 8'hDF));
      4: return 8'($urandom_range(8'hE0, 8'hEF));
      5: return 8'($urandom_range(8'hF0, 8'hFF));
      6: return ChAmp;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic bit [7:0] hex_char(bit [3:0] v, bit lower);
    if (v < 10) return 8'h30 + v;
    return (lower ? 8'h57 : 8'h37) + v;
  endfunction

  // queue one path string of well-formed utf-8 and escapes with some noise
  task automatic add_string();
    int n;
    bit [7:0] bs[$];
    bit [20:0] cp;
    in_item_t it;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: bs.push_back(8'($urandom_range(8'h20, 8'h7E)));
        2: begin
          cp = 21'($urandom_range(8'h80, 11'h7FF));
          bs.push_back(8'hC0 | cp[10:6]); bs.push_back(8'h80 | cp[5:0]);
        end
        3: begin
          cp = 21'($urandom_range(12'h800, 16'hFFFF));
          bs.push_back(8'hE0 | cp[15:12]); bs.push_back(8'h80 | cp[11:6]);
          bs.push_back(8'h80 | cp[5:0]);
        end
        4: begin
          cp = 21'($urandom_range(17'h10000, 18'h3FFFF));
          bs.push_back(8'hF0 | cp[20:18]); bs.push_back(8'h80 | cp[17:12]);
          bs.push_back(8'h80 | cp[11:6]); bs.push_back(8'h80 | cp[5:0]);
        end
        5, 6: begin
          cp = 21'($urandom);
          bs.push_back(ChPercent);
          bs.push_back(hex_char(cp[7:4], cp[8]));
          bs.push_back(hex_char(cp[3:0], cp[9]));
        end
        7: bs.push_back(8'($urandom_range(0, 8'h1F)));
        8: bs.push_back(ChAmp);
        default: bs.push_back(pick_byte());
      endcase
    end
    if ($urandom_range(0, 9) == 0) bs.push_back(ChPercent);
    foreach (bs[i]) begin
      it.in_byte = bs[i];
      it.in_last = (i == bs.size() - 1);
      path_bytes.push_back(it);
    end
  endtask

  task automatic add_directed(bit [7:0] b, bit last);
    in_item_t it;
    it.in_byte = b; it.in_last = last;
    path_bytes.push_back(it);
  endtask

  // offer one item and wait until the block takes it
  task automatic send_item(in_item_t it);
    while (!calm_sender && $urandom_range(0, 99) < 17) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // output side: random stalls, one long hold-off, checks at the rising edge
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 0;
        repeat (150) @(negedge clk);
        hold_receiver = 0;
      end
      out_ready <= calm_receiver || ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(out_data);
  end

  initial begin
    int waited;
    sb = new();
    sb.clear_state();
    sb.fail_count = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    calm_sender = 0;
    calm_receiver = 0;
    hold_receiver = 0;
    stim_done = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed strings: extremes, escapes, cut-short percent, bad hex, overlong
    add_directed(8'h00, 0); add_directed(8'hFF, 0); add_directed(8'h7F, 1);
    add_directed(ChAmp, 0); add_directed("A", 1);
    add_directed(ChPercent, 0); add_directed("4", 0); add_directed("a", 1);
    add_directed(ChPercent, 0); add_directed("g", 0); add_directed("z", 0);
    add_directed(8'hC3, 1);
    add_directed(ChPercent, 0); add_directed("E", 1);
    add_directed(ChPercent, 1);
    add_directed(8'hC0, 0); add_directed(8'h80, 0); add_directed(8'hE4, 0);
    add_directed("x", 0); add_directed(8'hB8, 0); add_directed(8'h80, 1);
    add_directed(8'hF0, 0); add_directed(8'h9F, 0); add_directed(8'h98, 0);
    add_directed(8'h80, 1);
    add_directed(8'h85, 0); add_directed(8'h01, 1);
    foreach (path_bytes[i]) send_item(path_bytes[i]);
    path_bytes.delete();

    // random strings; pause for a full drain partway through
    while (path_bytes.size() < 233) add_string();
    foreach (path_bytes[i]) begin
      if (i == 60) begin
        in_valid <= 0;
        @(negedge clk);
        while (sb.pending_bytes.size() != 0) @(negedge clk);
      end
      if (i == 100) hold_receiver = 1;
      calm_sender = (i >= 160 && i < 210);
      calm_receiver = calm_sender;
      send_item(path_bytes[i]);
    end
    in_valid <= 0;
    calm_sender = 0;
    calm_receiver = 1;

    waited = 0;
    while (sb.pending_bytes.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (30) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending_bytes.size() != 0)
        $error("%0d expected output items never came", sb.pending_bytes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
design/u8u7_pkg.sv
design/u8u7_front.sv
design/u8u7_queue.sv
design/u8u7_back.sv
design/url_utf8_to_modified_utf7.sv
tb/url_utf8_to_modified_utf7_test.sv
